FILE: rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types, codes and command bytes shared by the single-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // input word, one per clock of bus time
  typedef struct packed {
    logic       tick;
    logic       start_req;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       bus_level;
  } in_t;

  // result word, one per input word
  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        no_device;
    logic [15:0] read_value;
  } out_t;

  // timing registers
  typedef struct packed {
    logic [6:0] reset_low_ticks;
    logic [6:0] presence_wait_ticks;
    logic [6:0] recovery_ticks;
    logic [4:0] slot_ticks;
  } cfg_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECOVERY      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT          = 3'd3;

  localparam logic [6:0] RESET_LOW_DEFAULT     = 7'd60;
  localparam logic [6:0] PRESENCE_WAIT_DEFAULT = 7'd12;
  localparam logic [6:0] RECOVERY_DEFAULT      = 7'd24;
  localparam logic [4:0] SLOT_DEFAULT          = 5'd5;

  localparam logic [6:0] TICK_MAX = 7'd127;

  // operation codes
  localparam logic [2:0] OP_RESET     = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_CONVERT   = 3'd3;
  localparam logic [2:0] OP_READ_TEMP = 3'd4;

  // command bytes
  localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hbe;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_DATA  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_SAMP  = 4'd7,
    PH_RD_DATA  = 4'd8,
    PH_GAP      = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_END   = 2'd3
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [7:0] cmd;
  } step_t;

  // what each step of an operation does on the bus
  function automatic step_t action_of(logic [2:0] op, logic [2:0] step);
    step_t r;
    r.act = ACT_END;
    r.cmd = 8'h00;
    unique case (op)
      OP_RESET: begin
        if (step == 3'd0) r.act = ACT_RESET;
      end
      OP_WRITE: begin
        if (step == 3'd0) r.act = ACT_WRITE;
      end
      OP_READ: begin
        if (step == 3'd0) r.act = ACT_READ;
      end
      OP_CONVERT: begin
        if (step == 3'd0) begin
          r.act = ACT_RESET;
        end else if (step == 3'd1) begin
          r.act = ACT_WRITE;
          r.cmd = CMD_SKIP_ROM;
        end else if (step == 3'd2) begin
          r.act = ACT_WRITE;
          r.cmd = CMD_CONVERT;
        end
      end
      OP_READ_TEMP: begin
        if (step == 3'd0) begin
          r.act = ACT_RESET;
        end else if (step == 3'd1) begin
          r.act = ACT_WRITE;
          r.cmd = CMD_SKIP_ROM;
        end else if (step == 3'd2) begin
          r.act = ACT_WRITE;
          r.cmd = CMD_READ_PAD;
        end else if (step == 3'd3 || step == 3'd4) begin
          r.act = ACT_READ;
        end
      end
      default: r.act = ACT_END;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: timing registers, phase state and one update per input word.
// ----------------------------------------------------------------------------
module owm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_en_i,
  input  owm_pkg::in_t                 in_word_i,
  input  logic                         cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owm_pkg::CfgDataW-1:0] cfg_data_i,
  output owm_pkg::out_t                res_o
);

  owm_pkg::cfg_t   cfg_q;
  owm_pkg::phase_e phase_q, phase_d;
  logic [6:0]      tick_cnt_q, tick_cnt_d;
  logic [3:0]      bit_idx_q, bit_idx_d;
  logic [2:0]      step_idx_q, step_idx_d;
  logic [7:0]      shift_q, shift_d;
  logic [15:0]     result_q, result_d;
  logic            absent_q, absent_d;
  logic [2:0]      op_q, op_d;

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks     <= owm_pkg::RESET_LOW_DEFAULT;
      cfg_q.presence_wait_ticks <= owm_pkg::PRESENCE_WAIT_DEFAULT;
      cfg_q.recovery_ticks      <= owm_pkg::RECOVERY_DEFAULT;
      cfg_q.slot_ticks          <= owm_pkg::SLOT_DEFAULT;
    end else if (cfg_we_i) begin
      if (cfg_index_i == owm_pkg::CFG_RESET_LOW) cfg_q.reset_low_ticks <= cfg_data_i;
      if (cfg_index_i == owm_pkg::CFG_PRESENCE_WAIT) cfg_q.presence_wait_ticks <= cfg_data_i;
      if (cfg_index_i == owm_pkg::CFG_RECOVERY) cfg_q.recovery_ticks <= cfg_data_i;
      if (cfg_index_i == owm_pkg::CFG_SLOT) cfg_q.slot_ticks <= cfg_data_i[4:0];
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= owm_pkg::PH_IDLE;
      tick_cnt_q <= '0;
      bit_idx_q  <= '0;
      step_idx_q <= '0;
      shift_q    <= '0;
      result_q   <= '0;
      absent_q   <= 1'b0;
      op_q       <= '0;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      tick_cnt_q <= tick_cnt_d;
      bit_idx_q  <= bit_idx_d;
      step_idx_q <= step_idx_d;
      shift_q    <= shift_d;
      result_q   <= result_d;
      absent_q   <= absent_d;
      op_q       <= op_d;
    end
  end

  // next state and result for one word
  always_comb begin
    logic [6:0]     cnt_inc;
    logic [6:0]     target;
    logic           hit;
    logic           begin_req;
    logic [2:0]     begin_step;
    logic           done;
    owm_pkg::step_t cur_act;
    owm_pkg::step_t new_act;

    phase_d    = phase_q;
    tick_cnt_d = tick_cnt_q;
    bit_idx_d  = bit_idx_q;
    step_idx_d = step_idx_q;
    shift_d    = shift_q;
    result_d   = result_q;
    absent_d   = absent_q;
    op_d       = op_q;
    begin_req  = 1'b0;
    begin_step = 3'd0;
    done       = 1'b0;

    // tick counter shared by every timed phase
    cnt_inc = (tick_cnt_q < owm_pkg::TICK_MAX) ? tick_cnt_q + 7'd1 : tick_cnt_q;
    unique case (phase_q)
      owm_pkg::PH_RST_LOW:  target = cfg_q.reset_low_ticks;
      owm_pkg::PH_RST_WAIT: target = cfg_q.presence_wait_ticks;
      owm_pkg::PH_RST_REC:  target = cfg_q.recovery_ticks;
      owm_pkg::PH_WR_DATA,
      owm_pkg::PH_RD_DATA:  target = {2'b00, cfg_q.slot_ticks};
      default:              target = 7'd1;
    endcase
    hit = in_word_i.tick && (cnt_inc >= target);

    cur_act = owm_pkg::action_of(op_q, step_idx_q);

    unique case (phase_q)
      owm_pkg::PH_IDLE: begin
        if (in_word_i.start_req && in_word_i.operation <= owm_pkg::OP_READ_TEMP) begin
          op_d     = in_word_i.operation;
          absent_d = 1'b0;
          if (in_word_i.operation == owm_pkg::OP_WRITE) shift_d = in_word_i.write_data;
          if (in_word_i.operation == owm_pkg::OP_READ ||
              in_word_i.operation == owm_pkg::OP_READ_TEMP) result_d = '0;
          begin_req  = 1'b1;
          begin_step = 3'd0;
        end
      end
      owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW,
      owm_pkg::PH_WR_DATA, owm_pkg::PH_RD_DATA, owm_pkg::PH_RST_WAIT,
      owm_pkg::PH_RST_REC: begin
        if (in_word_i.tick) tick_cnt_d = cnt_inc;
        if (hit) begin
          tick_cnt_d = '0;
          unique case (phase_q)
            owm_pkg::PH_RST_LOW:  phase_d = owm_pkg::PH_RST_WAIT;
            owm_pkg::PH_RST_WAIT: begin
              absent_d = in_word_i.bus_level;
              phase_d  = owm_pkg::PH_RST_REC;
            end
            owm_pkg::PH_RST_REC: begin
              if (absent_q) begin
                phase_d = owm_pkg::PH_IDLE;
                done    = 1'b1;
              end else begin
                begin_req  = 1'b1;
                begin_step = step_idx_q + 3'd1;
              end
            end
            owm_pkg::PH_WR_LOW:   phase_d = owm_pkg::PH_WR_DATA;
            owm_pkg::PH_WR_DATA: begin
              shift_d   = {1'b0, shift_q[7:1]};
              bit_idx_d = bit_idx_q + 4'd1;
              phase_d   = owm_pkg::PH_GAP;
            end
            owm_pkg::PH_RD_LOW:   phase_d = owm_pkg::PH_RD_SAMP;
            default:              phase_d = owm_pkg::PH_GAP;
          endcase
        end
      end
      owm_pkg::PH_RD_SAMP: begin
        shift_d    = {in_word_i.bus_level, shift_q[7:1]};
        bit_idx_d  = bit_idx_q + 4'd1;
        phase_d    = owm_pkg::PH_RD_DATA;
        tick_cnt_d = '0;
      end
      owm_pkg::PH_GAP: begin
        if (bit_idx_q >= 4'd8) begin
          if (cur_act.act == owm_pkg::ACT_READ) begin
            if (op_q == owm_pkg::OP_READ_TEMP && step_idx_q == 3'd4)
              result_d = {shift_q, result_q[7:0]};
            else
              result_d = {8'h00, shift_q};
          end
          begin_req  = 1'b1;
          begin_step = step_idx_q + 3'd1;
        end else begin
          tick_cnt_d = '0;
          phase_d    = (cur_act.act == owm_pkg::ACT_READ) ? owm_pkg::PH_RD_LOW
                                                          : owm_pkg::PH_WR_LOW;
        end
      end
      default: begin
        phase_d    = owm_pkg::PH_IDLE;
        tick_cnt_d = '0;
      end
    endcase

    // entry into the next step of the operation
    new_act = owm_pkg::action_of(op_d, begin_step);
    if (begin_req) begin
      step_idx_d = begin_step;
      tick_cnt_d = '0;
      bit_idx_d  = '0;
      unique case (new_act.act)
        owm_pkg::ACT_RESET: phase_d = owm_pkg::PH_RST_LOW;
        owm_pkg::ACT_WRITE: begin
          if (op_d != owm_pkg::OP_WRITE) shift_d = new_act.cmd;
          phase_d = owm_pkg::PH_WR_LOW;
        end
        owm_pkg::ACT_READ: begin
          shift_d = '0;
          phase_d = owm_pkg::PH_RD_LOW;
        end
        default: begin
          phase_d = owm_pkg::PH_IDLE;
          done    = 1'b1;
        end
      endcase
    end

    // result word
    res_o.drive_low  = phase_d == owm_pkg::PH_RST_LOW || phase_d == owm_pkg::PH_WR_LOW ||
                       phase_d == owm_pkg::PH_RD_LOW ||
                       (phase_d == owm_pkg::PH_WR_DATA && !shift_d[0]);
    res_o.busy_res   = phase_d != owm_pkg::PH_IDLE;
    res_o.done_res   = done;
    res_o.no_device  = done && absent_d;
    res_o.read_value = result_d;
  end

endmodule

FILE: rtl/one_wire_temp_sensor_master.sv
// ----------------------------------------------------------------------------
// one_wire_temp_sensor_master
// Single-wire bus master with reset, byte write, byte read, convert and
// read-temperature sequences, timed in ticks of a 10 us strobe.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   in_word_i  (owm_pkg::in_t)
//  out       output     out_valid_o / out_stall_i out_word_o (owm_pkg::out_t)
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Each accepted input word updates the sequencer state, and its
//  result word is loaded into the output register at the accepting edge.
//  A word can be accepted every cycle; in_stall_o is high only while a held
//  result is stalled downstream. Reset returns the sequencer to idle and the
//  timing registers to 60, 12, 24 and 5 ticks. Config writes are always ready.
// ----------------------------------------------------------------------------
module one_wire_temp_sensor_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  owm_pkg::in_t                 in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output owm_pkg::out_t                out_word_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [owm_pkg::CfgDataW-1:0] cfg_data_i
);

  logic          accept;
  logic          out_valid_q, out_valid_d;
  owm_pkg::out_t out_word_q;
  owm_pkg::out_t res;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  owm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (accept),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
